>>> src/cfmf_pkg.sv
// Shared types and constants for the free-minute finder.
// Used by cfmf_mem, cfmf_divmod and common_free_minute_finder_unit; no dependencies.
`default_nettype none

package cfmf_pkg;

    // Default day geometry
    localparam int DEF_HOURS_PER_DAY    = 24;
    localparam int DEF_MINUTES_PER_HOUR = 60;

    // Map word organization
    localparam int WORD_BITS = 32;
    localparam int WORD_LG   = 5;

    // Field widths
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int POS_W  = 11;
    localparam int LEN_W  = 11;
    localparam int IDX_W  = 10;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_BREAK = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_BREAK  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE   = 2'd3;

endpackage

`default_nettype wire

>>> src/cfmf_mem.sv
// Busy-map word memory: one read and one write port, registered read data.
// Per-word valid bits make never-written and cleared words read as free. Uses cfmf_pkg.
`default_nettype none

module cfmf_mem #(
    parameter int NUM_WORDS = 45,
    parameter int ADDR_W    = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clr,
    input  wire logic                          rd_en,
    input  wire logic [ADDR_W-1:0]             rd_addr,
    output logic      [cfmf_pkg::WORD_BITS-1:0] rd_data,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [cfmf_pkg::WORD_BITS-1:0] wr_data
);
    import cfmf_pkg::*;

    logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_word_reg;
    logic [NUM_WORDS-1:0] word_valid_reg;
    logic                 rd_valid_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_q[rd_addr];
        end
    end

    // Valid bits: cleared at reset and by a clear request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                word_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                word_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= word_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

>>> src/cfmf_divmod.sv
// Minute-of-day to hour and minute by reciprocal multiplication, two pipeline stages.
// Uses cfmf_pkg.
`default_nettype none

module cfmf_divmod #(
    parameter int MINUTES_PER_HOUR = cfmf_pkg::DEF_MINUTES_PER_HOUR
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [cfmf_pkg::POS_W-1:0]  pos,
    output logic                            done,
    output logic      [cfmf_pkg::HOUR_W-1:0] hour,
    output logic      [cfmf_pkg::MIN_W-1:0]  minute
);
    import cfmf_pkg::*;

    // Rounded-up reciprocal; exact for every 11-bit position and divisor up to 64
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = POS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + MINUTES_PER_HOUR - 1) / MINUTES_PER_HOUR);

    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  pos_reg;
    logic [HOUR_W-1:0] quo_reg, quo_next;
    logic [POS_W-1:0]  back_prod;
    logic [POS_W-1:0]  rem_full;
    logic [HOUR_W-1:0] hour_reg;
    logic [MIN_W-1:0]  min_reg, min_next;
    logic              stage_reg;
    logic              done_reg;

    // Stage one: quotient; stage two: remainder from the quotient
    always_comb
    begin
        prod      = PROD_W'(pos) * PROD_W'(RECIP);
        quo_next  = prod[RECIP_SHIFT +: HOUR_W];
        back_prod = POS_W'(quo_reg) * POS_W'(MINUTES_PER_HOUR);
        rem_full  = pos_reg - back_prod;
        min_next  = rem_full[MIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pos_reg <= pos;
            quo_reg <= quo_next;
        end
        if (stage_reg)
        begin
            hour_reg <= quo_reg;
            min_reg  <= min_next;
        end
    end

    assign done   = done_reg;
    assign hour   = hour_reg;
    assign minute = min_reg;

endmodule

`default_nettype wire

>>> src/common_free_minute_finder_unit.sv
// Free-minute finder top level: request handling, map walk and result register.
// Depends on cfmf_pkg, cfmf_mem and cfmf_divmod.
//
// The day is kept as a busy bitmap, one bit per minute, stored as 32-bit words in a
// single memory with registered read data. Requests are handled one at a time. An
// add visits each map word its interval touches (read, then OR-in and write back).
// A next-break request walks the map one word per cycle from the scan cursor, first
// for a free minute and then for the next busy one, then turns start and end into
// hour:minute through a shared two-stage reciprocal-multiply converter. A clear
// drops the per-word valid bits, so no clearing pass is needed after reset or clear.
// A finished request waits in its done state while the output register is stalled.
// A new request may be accepted while the previous result still waits in the output
// register.
`default_nettype none

module common_free_minute_finder_unit #(
    parameter int HOURS_PER_DAY    = cfmf_pkg::DEF_HOURS_PER_DAY,
    parameter int MINUTES_PER_HOUR = cfmf_pkg::DEF_MINUTES_PER_HOUR
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [cfmf_pkg::OP_W-1:0]   operation,
    input  wire logic [cfmf_pkg::HOUR_W-1:0] start_hour,
    input  wire logic [cfmf_pkg::MIN_W-1:0]  start_minute,
    input  wire logic [cfmf_pkg::LEN_W-1:0]  duration,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [cfmf_pkg::STAT_W-1:0] status,
    output logic      [cfmf_pkg::HOUR_W-1:0] break_start_hour,
    output logic      [cfmf_pkg::MIN_W-1:0]  break_start_minute,
    output logic      [cfmf_pkg::HOUR_W-1:0] break_end_hour,
    output logic      [cfmf_pkg::MIN_W-1:0]  break_end_minute,
    output logic      [cfmf_pkg::LEN_W-1:0]  break_length,
    output logic      [cfmf_pkg::IDX_W-1:0]  break_index
);
    import cfmf_pkg::*;

    localparam int DAY_MINUTES = HOURS_PER_DAY * MINUTES_PER_HOUR;
    localparam int NUM_WORDS   = (DAY_MINUTES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LAST_BITS   = DAY_MINUTES - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        (LAST_BITS == WORD_BITS) ? {WORD_BITS{1'b1}}
                                 : WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);
    localparam logic [POS_W-1:0] DAY_POS  = POS_W'(DAY_MINUTES);
    localparam logic [POS_W-1:0] DAY_LAST = POS_W'(DAY_MINUTES - 1);
    localparam int SUM_W = POS_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_BRK_FREE,
        S_BRK_BUSY,
        S_DIV_F,
        S_DIV_E,
        S_DONE
    } state_t;

    // Lowest set bit of a word
    function automatic logic [WORD_LG-1:0] first_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_LG-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (w[b])
            begin
                idx = WORD_LG'(b);
            end
        end
        return idx;
    endfunction

    state_t               state_reg, state_next;
    logic [POS_W-1:0]     cursor_reg, cursor_next;
    logic [IDX_W-1:0]     breaks_reg, breaks_next;
    logic [POS_W-1:0]     first_reg, first_next;
    logic [POS_W-1:0]     last_reg, last_next;
    logic [WORD_AW-1:0]   wptr_reg, wptr_next;
    logic [WORD_LG:0]     off_reg, off_next;
    logic [POS_W-1:0]     f_reg, f_next;
    logic [POS_W-1:0]     e_reg, e_next;
    logic [HOUR_W-1:0]    fh_reg, fh_next;
    logic [MIN_W-1:0]     fm_reg, fm_next;
    logic [HOUR_W-1:0]    eh_reg, eh_next;
    logic [MIN_W-1:0]     em_reg, em_next;
    logic [STAT_W-1:0]    pend_reg, pend_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [HOUR_W-1:0]    bsh_reg, bsh_next;
    logic [MIN_W-1:0]     bsm_reg, bsm_next;
    logic [HOUR_W-1:0]    beh_reg, beh_next;
    logic [MIN_W-1:0]     bem_reg, bem_next;
    logic [LEN_W-1:0]     blen_reg, blen_next;
    logic [IDX_W-1:0]     bidx_reg, bidx_next;

    // memory and divider control
    logic                 mem_clr, mem_rd_en, mem_wr_en;
    logic [WORD_AW-1:0]   mem_rd_addr, mem_wr_addr;
    logic [WORD_BITS-1:0] mem_rd_data, mem_wr_data;
    logic                 div_start, div_done;
    logic [POS_W-1:0]     div_pos;
    logic [HOUR_W-1:0]    div_hour;
    logic [MIN_W-1:0]     div_minute;

    // datapath helpers
    logic [SUM_W-1:0]     add_first, add_last;
    logic                 add_bad;
    logic [WORD_AW-1:0]   first_word, last_word;
    logic [WORD_LG-1:0]   mask_lo, mask_hi;
    logic [WORD_BITS-1:0] fill_mask;
    logic [WORD_BITS-1:0] in_day, from_off, cand_free, cand_busy;
    logic [WORD_LG-1:0]   free_idx, busy_idx;
    logic [POS_W-1:0]     word_base;
    logic                 out_free;

    cfmf_mem #(
        .NUM_WORDS (NUM_WORDS),
        .ADDR_W    (WORD_AW)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    cfmf_divmod #(
        .MINUTES_PER_HOUR (MINUTES_PER_HOUR)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .pos    (div_pos),
        .done   (div_done),
        .hour   (div_hour),
        .minute (div_minute)
    );

    // Add interval bounds and range check
    always_comb
    begin
        add_first = SUM_W'(start_hour) * SUM_W'(MINUTES_PER_HOUR) + SUM_W'(start_minute);
        add_last  = add_first + SUM_W'(duration);
        add_bad   = (start_hour >= HOUR_W'(HOURS_PER_DAY))
                 || (start_minute >= MIN_W'(MINUTES_PER_HOUR))
                 || (add_last >= SUM_W'(DAY_MINUTES));
    end

    // Fill mask for the word under the pointer
    always_comb
    begin
        first_word = first_reg[WORD_LG +: WORD_AW];
        last_word  = last_reg[WORD_LG +: WORD_AW];
        mask_lo    = (wptr_reg == first_word) ? first_reg[WORD_LG-1:0] : '0;
        mask_hi    = (wptr_reg == last_word) ? last_reg[WORD_LG-1:0]
                                             : WORD_LG'(WORD_BITS - 1);
        fill_mask  = ({WORD_BITS{1'b1}} << mask_lo)
                   & ({WORD_BITS{1'b1}} >> (WORD_LG'(WORD_BITS - 1) - mask_hi));
    end

    // Run search candidates; minutes past the day end count as busy
    always_comb
    begin
        in_day    = (wptr_reg == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}};
        from_off  = off_reg[WORD_LG] ? '0 : ({WORD_BITS{1'b1}} << off_reg[WORD_LG-1:0]);
        cand_free = ~mem_rd_data & in_day & from_off;
        cand_busy = (mem_rd_data | ~in_day) & from_off;
        free_idx  = first_set(cand_free);
        busy_idx  = first_set(cand_busy);
        word_base = POS_W'(wptr_reg) << WORD_LG;
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        breaks_next    = breaks_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        wptr_next      = wptr_reg;
        off_next       = off_reg;
        f_next         = f_reg;
        e_next         = e_reg;
        fh_next        = fh_reg;
        fm_next        = fm_reg;
        eh_next        = eh_reg;
        em_next        = em_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        bsh_next       = bsh_reg;
        bsm_next       = bsm_reg;
        beh_next       = beh_reg;
        bem_next       = bem_reg;
        blen_next      = blen_reg;
        bidx_next      = bidx_reg;
        mem_clr        = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = wptr_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = wptr_reg;
        mem_wr_data    = mem_rd_data | fill_mask;
        div_start      = 1'b0;
        div_pos        = f_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DONE;
                    pend_next  = ST_OK;
                    case (operation)
                        OP_ADD:
                        begin
                            if (add_bad)
                            begin
                                pend_next = ST_REJECT;
                            end
                            else
                            begin
                                first_next = add_first[POS_W-1:0];
                                last_next  = add_last[POS_W-1:0];
                                wptr_next  = add_first[WORD_LG +: WORD_AW];
                                state_next = S_ADD_RD;
                            end
                        end
                        OP_BREAK:
                        begin
                            if (cursor_reg >= DAY_POS)
                            begin
                                pend_next = ST_NONE;
                            end
                            else
                            begin
                                wptr_next   = cursor_reg[WORD_LG +: WORD_AW];
                                off_next    = {1'b0, cursor_reg[WORD_LG-1:0]};
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = cursor_reg[WORD_LG +: WORD_AW];
                                state_next  = S_BRK_FREE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            mem_clr     = 1'b1;
                            cursor_next = '0;
                            breaks_next = '0;
                        end
                        default:
                        begin
                            pend_next = ST_OK;
                        end
                    endcase
                end
            end

            S_ADD_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = S_ADD_WR;
            end

            // OR the interval into the word just read
            S_ADD_WR:
            begin
                mem_wr_en = 1'b1;
                if (wptr_reg == last_word)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wptr_next  = wptr_reg + WORD_AW'(1);
                    state_next = S_ADD_RD;
                end
            end

            // look for the first free minute
            S_BRK_FREE:
            begin
                if (cand_free != '0)
                begin
                    f_next     = word_base | POS_W'(free_idx);
                    off_next   = (WORD_LG + 1)'(free_idx) + (WORD_LG + 1)'(1);
                    state_next = S_BRK_BUSY;
                end
                else if (wptr_reg == LAST_WORD)
                begin
                    pend_next  = ST_NONE;
                    state_next = S_DONE;
                end
                else
                begin
                    wptr_next   = wptr_reg + WORD_AW'(1);
                    off_next    = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = wptr_reg + WORD_AW'(1);
                end
            end

            // look for the end of the free run
            S_BRK_BUSY:
            begin
                if (cand_busy != '0)
                begin
                    e_next     = (word_base | POS_W'(busy_idx)) - POS_W'(1);
                    div_start  = 1'b1;
                    state_next = S_DIV_F;
                end
                else if (wptr_reg == LAST_WORD)
                begin
                    e_next     = DAY_LAST;
                    div_start  = 1'b1;
                    state_next = S_DIV_F;
                end
                else
                begin
                    wptr_next   = wptr_reg + WORD_AW'(1);
                    off_next    = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = wptr_reg + WORD_AW'(1);
                end
            end

            S_DIV_F:
            begin
                if (div_done)
                begin
                    fh_next    = div_hour;
                    fm_next    = div_minute;
                    div_start  = 1'b1;
                    div_pos    = e_reg;
                    state_next = S_DIV_E;
                end
            end

            S_DIV_E:
            begin
                if (div_done)
                begin
                    eh_next    = div_hour;
                    em_next    = div_minute;
                    pend_next  = ST_BREAK;
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_reg;
                    bsh_next       = '0;
                    bsm_next       = '0;
                    beh_next       = '0;
                    bem_next       = '0;
                    blen_next      = '0;
                    bidx_next      = '0;
                    if (pend_reg == ST_BREAK)
                    begin
                        bsh_next    = fh_reg;
                        bsm_next    = fm_reg;
                        beh_next    = eh_reg;
                        bem_next    = em_reg;
                        blen_next   = LEN_W'(e_reg - f_reg + POS_W'(1));
                        bidx_next   = breaks_reg;
                        cursor_next = e_reg + POS_W'(1);
                        breaks_next = breaks_reg + IDX_W'(1);
                    end
                    else if (pend_reg == ST_NONE)
                    begin
                        cursor_next = '0;
                        breaks_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            breaks_reg    <= '0;
            pend_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            breaks_reg    <= breaks_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        last_reg   <= last_next;
        wptr_reg   <= wptr_next;
        off_reg    <= off_next;
        f_reg      <= f_next;
        e_reg      <= e_next;
        fh_reg     <= fh_next;
        fm_reg     <= fm_next;
        eh_reg     <= eh_next;
        em_reg     <= em_next;
        status_reg <= status_next;
        bsh_reg    <= bsh_next;
        bsm_reg    <= bsm_next;
        beh_reg    <= beh_next;
        bem_reg    <= bem_next;
        blen_reg   <= blen_next;
        bidx_reg   <= bidx_next;
    end

    assign in_stall           = (state_reg != S_IDLE);
    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign break_start_hour   = bsh_reg;
    assign break_start_minute = bsm_reg;
    assign break_end_hour     = beh_reg;
    assign break_end_minute   = bem_reg;
    assign break_length       = blen_reg;
    assign break_index        = bidx_reg;

endmodule

`default_nettype wire
